[hw/rtl/lkc_pkg.sv]
package lkc_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int KEY_W       = 64;
	localparam int SIZE_W      = 6;
	localparam int COST_W      = 3;
	localparam int TOTAL_W     = 32;

	localparam logic [SIZE_W-1:0]  SIZE_RESET = 6'd3;
	localparam logic [COST_W-1:0]  HIT_COST   = 3'd1;
	localparam logic [COST_W-1:0]  MISS_COST  = 3'd5;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_FINISH
	} state_t;

endpackage

[hw/rtl/lkc_if.sv]
interface lkc_key_if;
	logic                     valid;
	logic                     ready;
	logic [lkc_pkg::KEY_W-1:0] key;

	modport source (output valid, output key, input ready);
	modport sink   (input valid, input key, output ready);
endinterface

interface lkc_result_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [lkc_pkg::COST_W-1:0]  cost;
	logic [lkc_pkg::TOTAL_W-1:0] total_cost;

	modport source (output valid, output hit, output cost, output total_cost, input ready);
	modport sink   (input valid, input hit, input cost, input total_cost, output ready);
endinterface

[hw/rtl/lru_key_cache_cost_top.sv]
// Channel   Dir  Handshake      Payload
// key_ch    in   valid/ready    key[63:0]
// res_ch    out  valid/ready    hit, cost[2:0], total_cost[31:0]
// cfg       in   cfg_we         cfg_wdata[5:0] -> cache_size
//
// A request is accepted in idle, then scans the held entries (at most 32), decides,
// sweeps the entries again to update their ages, and finishes; with cache_size 0
// the age sweep is skipped. Scan and age sweep each read one entry a cycle.
// Reset empties the cache, clears the total, sets cache_size to 3; a size write
// empties the cache and keeps the total. key_ch.ready is high only in idle; a
// finished request stalls only while the output register holds a waiting result.
module lru_key_cache_cost_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [lkc_pkg::SIZE_W-1:0]   cfg_wdata,
	lkc_key_if.sink                      key_ch,
	lkc_result_if.source                 res_ch
);

	// key store and recency ranks (0 = most recent)
	logic [lkc_pkg::KEY_W-1:0] key_mem [lkc_pkg::MAX_ENTRIES];
	logic [lkc_pkg::IDX_W-1:0] age_mem [lkc_pkg::MAX_ENTRIES];

	lkc_pkg::state_t state_q, state_d;

	logic [lkc_pkg::SIZE_W-1:0]  cache_size_q;
	logic [lkc_pkg::CNT_W-1:0]   held_q;
	logic [lkc_pkg::CNT_W-1:0]   idx_q;
	logic                        rd_vld_s1;
	logic [lkc_pkg::IDX_W-1:0]   rd_idx_s1;
	logic [lkc_pkg::KEY_W-1:0]   key_rd_s1;
	logic [lkc_pkg::IDX_W-1:0]   age_rd_s1;
	logic [lkc_pkg::TOTAL_W-1:0] total_q;

	logic                        hit_q;
	logic [lkc_pkg::KEY_W-1:0]   key_q;
	logic [lkc_pkg::IDX_W-1:0]   slot_q;
	logic [lkc_pkg::CNT_W-1:0]   old_q;
	logic [lkc_pkg::IDX_W-1:0]   victim_q;

	logic                        out_valid_q;
	logic                        out_hit_q;
	logic [lkc_pkg::COST_W-1:0]  out_cost_q;
	logic [lkc_pkg::TOTAL_W-1:0] out_total_q;

	// control strobes
	logic                        accept;
	logic                        rd_en;
	logic                        sweep_done;
	logic                        key_we;
	logic [lkc_pkg::IDX_W-1:0]   key_waddr;
	logic                        age_we;
	logic [lkc_pkg::IDX_W-1:0]   age_wdata;
	logic                        out_load;
	logic [lkc_pkg::CNT_W-1:0]   cap;
	logic                        has_room;
	logic [lkc_pkg::IDX_W-1:0]   held_last;
	logic [lkc_pkg::COST_W-1:0]  cost;
	logic [lkc_pkg::TOTAL_W:0]   sum;
	logic [lkc_pkg::TOTAL_W-1:0] total_next;

	// capacity saturates at the store depth
	assign cap = (cache_size_q > lkc_pkg::SIZE_W'(lkc_pkg::MAX_ENTRIES))
		? lkc_pkg::CNT_W'(lkc_pkg::MAX_ENTRIES)
		: lkc_pkg::CNT_W'(cache_size_q);
	assign has_room  = held_q < cap;
	assign held_last = held_q[lkc_pkg::IDX_W-1:0] - lkc_pkg::IDX_W'(1);

	assign cost       = hit_q ? lkc_pkg::HIT_COST : lkc_pkg::MISS_COST;
	assign sum        = {1'b0, total_q} + (lkc_pkg::TOTAL_W+1)'(cost);
	assign total_next = sum[lkc_pkg::TOTAL_W] ? lkc_pkg::TOTAL_MAX
		: sum[lkc_pkg::TOTAL_W-1:0];

	// entries younger than the promoted one age by one; the promoted one goes to 0
	assign age_wdata = (rd_idx_s1 == slot_q) ? '0
		: ((lkc_pkg::CNT_W'(age_rd_s1) < old_q) ? age_rd_s1 + lkc_pkg::IDX_W'(1)
		: age_rd_s1);

	assign key_waddr = has_room ? held_q[lkc_pkg::IDX_W-1:0] : victim_q;

	always_comb begin
		state_d    = state_q;
		accept     = 1'b0;
		rd_en      = 1'b0;
		key_we     = 1'b0;
		age_we     = 1'b0;
		out_load   = 1'b0;
		sweep_done = (idx_q >= held_q) && !rd_vld_s1;
		case (state_q)
			lkc_pkg::ST_IDLE: begin
				accept = key_ch.valid;
				if (key_ch.valid) begin
					state_d = lkc_pkg::ST_SCAN;
				end
			end
			lkc_pkg::ST_SCAN: begin
				rd_en = idx_q < held_q;
				if (sweep_done) begin
					state_d = lkc_pkg::ST_DECIDE;
				end
			end
			lkc_pkg::ST_DECIDE: begin
				if (!hit_q && cap == '0) begin
					state_d = lkc_pkg::ST_FINISH;
				end else begin
					key_we  = !hit_q;
					state_d = lkc_pkg::ST_UPDATE;
				end
			end
			lkc_pkg::ST_UPDATE: begin
				rd_en  = idx_q < held_q;
				age_we = rd_vld_s1;
				if (sweep_done) begin
					state_d = lkc_pkg::ST_FINISH;
				end
			end
			lkc_pkg::ST_FINISH: begin
				out_load = !out_valid_q || res_ch.ready;
				if (out_load) begin
					state_d = lkc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lkc_pkg::ST_IDLE;
			end
		endcase
	end

	assign key_ch.ready      = (state_q == lkc_pkg::ST_IDLE);
	assign res_ch.valid      = out_valid_q;
	assign res_ch.hit        = out_hit_q;
	assign res_ch.cost       = out_cost_q;
	assign res_ch.total_cost = out_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_size_q <= lkc_pkg::SIZE_RESET;
			held_q       <= '0;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			total_q      <= '0;
			hit_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cache_size_q <= cfg_wdata;
				held_q       <= '0;
			end
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				idx_q <= idx_q + lkc_pkg::CNT_W'(1);
			end
			if (accept) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end
			if (state_q == lkc_pkg::ST_SCAN && rd_vld_s1 && !hit_q && key_rd_s1 == key_q) begin
				hit_q <= 1'b1;
			end
			if (state_q == lkc_pkg::ST_DECIDE) begin
				idx_q <= '0;
				if (!hit_q && cap != '0 && has_room) begin
					held_q <= held_q + lkc_pkg::CNT_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				total_q     <= total_next;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request payload and scan results
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key_ch.key;
		end
		rd_idx_s1 <= idx_q[lkc_pkg::IDX_W-1:0];
		if (state_q == lkc_pkg::ST_SCAN && rd_vld_s1) begin
			if (!hit_q && key_rd_s1 == key_q) begin
				slot_q <= rd_idx_s1;
				old_q  <= lkc_pkg::CNT_W'(age_rd_s1);
			end
			if (age_rd_s1 == held_last) begin
				victim_q <= rd_idx_s1;
			end
		end
		if (state_q == lkc_pkg::ST_DECIDE && !hit_q) begin
			if (has_room) begin
				// new entry: every held entry ages
				slot_q <= held_q[lkc_pkg::IDX_W-1:0];
				old_q  <= held_q;
			end else begin
				slot_q <= victim_q;
				old_q  <= lkc_pkg::CNT_W'(held_last);
			end
		end
		if (out_load) begin
			out_hit_q   <= hit_q;
			out_cost_q  <= cost;
			out_total_q <= total_next;
		end
	end

	// memories: one read port (registered), one write port each
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_q;
		end
		if (rd_en) begin
			key_rd_s1 <= key_mem[idx_q[lkc_pkg::IDX_W-1:0]];
			age_rd_s1 <= age_mem[idx_q[lkc_pkg::IDX_W-1:0]];
		end
		if (age_we) begin
			age_mem[rd_idx_s1] <= age_wdata;
		end
	end

endmodule

[verif/lru_key_cache_cost_top_tb.sv]
`timescale 1ns / 1ps

module lru_key_cache_cost_top_tb;

	// run length guard: room for ~700 requests, plus stalls, many times over
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 80;
	localparam int RAND_PHASES   = 10;
	localparam int PHASE_ITEMS   = 70;
	localparam int POOL_DEPTH    = 48;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic                        hit;
		logic [lkc_pkg::COST_W-1:0]  cost;
		logic [lkc_pkg::TOTAL_W-1:0] total_cost;
	} access_cost_t;

	// Tracks the LRU contents and the running cost; one expectation per request.
	class lru_cost_tracker;
		logic [lkc_pkg::SIZE_W-1:0]  cache_size;
		logic [lkc_pkg::KEY_W-1:0]   held_keys[lkc_pkg::MAX_ENTRIES];
		int unsigned                 recency[lkc_pkg::MAX_ENTRIES];
		int unsigned                 held;
		logic [lkc_pkg::TOTAL_W-1:0] total;
		access_cost_t                expected_costs[$];
		int                          errors;
		int                          checked;
		int                          hits;
		int                          misses;

		function new();
			cache_size = lkc_pkg::SIZE_RESET;
			held       = 0;
			total      = '0;
			errors     = 0;
			checked    = 0;
			hits       = 0;
			misses     = 0;
			foreach (recency[i]) recency[i] = 0;
		endfunction

		// any write flushes the cache, the total survives
		function void set_size(logic [lkc_pkg::SIZE_W-1:0] v);
			cache_size = v;
			held       = 0;
		endfunction

		function void make_newest(int unsigned s);
			int unsigned prev;
			prev = recency[s];
			for (int unsigned i = 0; i < held; i++)
				if (i != s && recency[i] < prev)
					recency[i]++;
			recency[s] = 0;
		endfunction

		function void note_access(logic [lkc_pkg::KEY_W-1:0] k);
			int unsigned  cap;
			int unsigned  slot;
			int unsigned  oldest;
			bit           found;
			longint       sum;
			access_cost_t e;
			cap   = (cache_size > lkc_pkg::MAX_ENTRIES) ? lkc_pkg::MAX_ENTRIES : cache_size;
			found = 0;
			slot  = 0;
			if (held > cap)
				held = cap;
			for (int unsigned i = 0; i < held; i++)
				if (!found && held_keys[i] == k) begin
					found = 1;
					slot  = i;
				end
			if (found) begin
				make_newest(slot);
			end else if (cap != 0) begin
				if (held < cap) begin
					slot            = held;
					held_keys[slot] = k;
					recency[slot]   = held;
					held++;
					make_newest(slot);
				end else begin
					oldest = 0;
					for (int unsigned i = 0; i < held; i++)
						if (recency[i] > oldest) begin
							oldest = recency[i];
							slot   = i;
						end
					held_keys[slot] = k;
					make_newest(slot);
				end
			end
			e.hit  = found;
			e.cost = found ? lkc_pkg::HIT_COST : lkc_pkg::MISS_COST;
			sum    = longint'(total) + longint'(e.cost);
			total  = (sum > longint'(lkc_pkg::TOTAL_MAX)) ? lkc_pkg::TOTAL_MAX
				: sum[lkc_pkg::TOTAL_W-1:0];
			e.total_cost = total;
			if (found)
				hits++;
			else
				misses++;
			expected_costs = {expected_costs, e};
		endfunction

		function void check_result(logic h, logic [lkc_pkg::COST_W-1:0] c,
				logic [lkc_pkg::TOTAL_W-1:0] t);
			access_cost_t e;
			if (expected_costs.size() == 0) begin
				$error("result with nothing outstanding: hit %0d cost %0d total %0d", h, c, t);
				errors++;
				return;
			end
			e = expected_costs.pop_front();
			checked++;
			if (h !== e.hit) begin
				$error("hit: expected %0d, actual %0d", e.hit, h);
				errors++;
			end
			if (c !== e.cost) begin
				$error("cost: expected %0d, actual %0d", e.cost, c);
				errors++;
			end
			if (t !== e.total_cost) begin
				$error("total_cost: expected %0d, actual %0d", e.total_cost, t);
				errors++;
			end
		endfunction

		function int pending();
			return expected_costs.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [lkc_pkg::SIZE_W-1:0] cfg_wdata;

	lkc_key_if    key_ch ();
	lkc_result_if res_ch ();

	lru_key_cache_cost_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.key_ch    (key_ch),
		.res_ch    (res_ch)
	);

	lru_cost_tracker tracker = new();

	int                        gap_pct;
	int                        stall_pct;
	int                        cycle_count;
	int                        size_writes;
	logic [lkc_pkg::KEY_W-1:0] key_pool[POOL_DEPTH];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop; nothing in a correct run gets near this
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, tracker.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side back-pressure, redrawn every cycle
	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99) >= stall_pct);

	// monitors: sample at the rising edge, predict on accept, check on return
	always @(posedge clk) begin
		if (arst_n && key_ch.valid && key_ch.ready)
			tracker.note_access(key_ch.key);
		if (arst_n && res_ch.valid && res_ch.ready)
			tracker.check_result(res_ch.hit, res_ch.cost, res_ch.total_cost);
	end

	task automatic set_idle(idle_mode_t m);
		case (m)
			IDLE_NONE: begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				gap_pct   = 71;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				gap_pct   = 0;
				stall_pct = 71;
			end
			default: begin
				gap_pct   = 21;
				stall_pct = 21;
			end
		endcase
	endtask

	// One request. Valid stays high into the next request unless a gap is drawn,
	// so each negedge carries a single assignment to valid.
	task automatic send_key(logic [lkc_pkg::KEY_W-1:0] k);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			key_ch.valid <= 1'b0;
			@(negedge clk);
		end
		key_ch.valid <= 1'b1;
		key_ch.key   <= k;
		@(posedge clk);
		while (!key_ch.ready)
			@(posedge clk);
	endtask

	task automatic release_key();
		@(negedge clk);
		key_ch.valid <= 1'b0;
	endtask

	// every request answered, plus a little slack for the FSM to get back to idle
	task automatic wait_drained();
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// only legal with the block idle
	task automatic write_size(logic [lkc_pkg::SIZE_W-1:0] v);
		release_key();
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		tracker.set_size(v);
		size_writes++;
	endtask

	// Mostly keys from a pool sized a bit past the capacity, so hits, fills and
	// evictions all show up; some single-bit neighbors to stress the compare,
	// and some fully random keys.
	function automatic logic [lkc_pkg::KEY_W-1:0] pick_key(int span);
		int                        sel;
		logic [lkc_pkg::KEY_W-1:0] k;
		sel = $urandom_range(99);
		if (sel < 80) begin
			k = key_pool[$urandom_range(span)];
		end else if (sel < 88) begin
			k = key_pool[$urandom_range(span)];
			k[$urandom_range(lkc_pkg::KEY_W-1)] ^= 1'b1;
		end else begin
			k = {$urandom, $urandom};
		end
		return k;
	endfunction

	initial begin
		logic [lkc_pkg::SIZE_W-1:0] phase_sizes[RAND_PHASES];
		int unsigned                cap;
		int                         span;

		phase_sizes = '{6'd32, 6'd7, 6'd0, 6'd63, 6'd1, 6'd20, 6'd33, 6'd2, 6'd3, 6'd12};
		size_writes  = 0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		key_ch.valid = 1'b0;
		key_ch.key   = '0;
		set_idle(IDLE_NONE);
		foreach (key_pool[i])
			key_pool[i] = {$urandom, $urandom};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed ---
		// reset capacity of three: fill, hit, evict the least recent
		send_key('0);
		send_key('1);
		send_key('0);
		send_key(64'h1);
		send_key(64'h2);
		send_key('1);
		send_key('0);

		// capacity zero: a repeated key still misses
		write_size(6'd0);
		send_key(64'h8000_0000_0000_0000);
		send_key(64'h8000_0000_0000_0000);

		// largest register value clamps to the full store
		write_size(6'h3f);
		send_key('1);
		send_key('0);
		send_key(64'h5555_5555_5555_5555);
		send_key('1);

		// single entry: every new key evicts; a rewrite of the same size flushes
		write_size(6'd1);
		send_key(64'h5);
		send_key(64'h5);
		send_key(64'h6);
		send_key(64'h5);
		write_size(6'd1);
		send_key(64'h5);

		// --- random phases, cycling through the idle patterns ---
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_size(phase_sizes[p]);
			set_idle(idle_mode_t'(p % 4));
			cap  = (phase_sizes[p] > lkc_pkg::MAX_ENTRIES) ? lkc_pkg::MAX_ENTRIES
				: phase_sizes[p];
			span = cap + cap / 3 + 4;
			if (span > POOL_DEPTH - 1)
				span = POOL_DEPTH - 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold off the sender until the pipe is empty, once for sure
				if ((p == 0 && n == 10) || $urandom_range(49) == 0) begin
					release_key();
					wait_drained();
				end
				send_key(pick_key(span));
			end
		end

		release_key();
		set_idle(IDLE_NONE);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (tracker.pending() != 0) begin
			$error("%0d expected results never arrived", tracker.pending());
			tracker.errors++;
		end

		$display("covered %0d key requests (%0d hits, %0d misses) over %0d capacity writes",
			tracker.hits + tracker.misses, tracker.hits, tracker.misses, size_writes);
		$display("%0d results checked, %0d mismatches", tracker.checked, tracker.errors);
		if (tracker.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
